// ===== hw/rtl/ccw_pkg.sv =====
`timescale 1ns / 1ps

package ccw_pkg;

    localparam logic [11:0] YEAR_FIRST    = 12'd2000;
    localparam logic [11:0] YEAR_LAST     = 12'd2199;
    localparam logic [11:0] CENTURY_SPLIT = 12'd2099;
    localparam logic [11:0] YEAR_NO_LEAP  = 12'd2100;
    localparam logic [5:0]  SEC_MAX       = 6'd59;
    localparam logic [5:0]  MIN_MAX       = 6'd59;
    localparam logic [4:0]  HOUR_MAX      = 5'd23;
    localparam logic [3:0]  MONTH_MAX     = 4'd12;
    localparam logic [7:0]  CCODE_EARLY   = 8'd6;
    localparam logic [7:0]  CCODE_LATE    = 8'd4;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_time;

    localparam t_time TIME_RESET = '{
        year: YEAR_FIRST, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0, second: 6'd0
    };

    // leap rule over the supported range: 2000 is leap, 2100 is not
    function automatic logic leap_year(input logic [11:0] y);
        leap_year = (y[1:0] == 2'b00) && (y != YEAR_NO_LEAP);
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic [11:0] y);
        case (m) inside
            4'd2:                                  month_length = leap_year(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:               month_length = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_length = 5'd31;
            default:                               month_length = 5'd0;
        endcase
    endfunction

    function automatic logic [7:0] month_code(input logic [3:0] m);
        case (m)
            4'd1:    month_code = 8'd0;
            4'd2:    month_code = 8'd3;
            4'd3:    month_code = 8'd3;
            4'd4:    month_code = 8'd6;
            4'd5:    month_code = 8'd1;
            4'd6:    month_code = 8'd4;
            4'd7:    month_code = 8'd6;
            4'd8:    month_code = 8'd2;
            4'd9:    month_code = 8'd5;
            4'd10:   month_code = 8'd0;
            4'd11:   month_code = 8'd3;
            4'd12:   month_code = 8'd5;
            default: month_code = 8'd0;
        endcase
    endfunction

    // 8 = 1 mod 7: fold octal digits, then subtract 14 or 7 at most once
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [4:0] s;
        s = {3'b000, x[7:6]} + {2'b00, x[5:3]} + {2'b00, x[2:0]};
        if (s >= 5'd14) begin
            s = s - 5'd14;
        end else if (s >= 5'd7) begin
            s = s - 5'd7;
        end
        mod7 = s[2:0];
    endfunction

    // 0 Monday .. 6 Sunday
    function automatic logic [2:0] weekday_of(input t_time t);
        logic [11:0] off;
        logic [7:0]  yc;
        logic [7:0]  total;
        logic [2:0]  w;
        off   = t.year - YEAR_FIRST;
        yc    = (off >= 12'd100) ? 8'(off - 12'd100) : off[7:0];
        total = yc + {2'b00, yc[7:2]} + month_code(t.month)
              + ((t.year > CENTURY_SPLIT) ? CCODE_LATE : CCODE_EARLY)
              + {3'b000, t.day} + 8'd7
              - {7'd0, (leap_year(t.year) && (t.month <= 4'd2))};
        w = mod7(total);
        weekday_of = (w == 3'd0) ? 3'd6 : w - 3'd1;
    endfunction

endpackage

// ===== hw/rtl/ccw_next.sv =====
`timescale 1ns / 1ps

module ccw_next
    import ccw_pkg::*;
(
    input  t_time       i_cur,
    input  logic        i_mode,
    input  logic [11:0] i_new_year,
    input  logic [3:0]  i_new_month,
    input  logic [4:0]  i_new_day,
    input  logic [4:0]  i_new_hour,
    input  logic [5:0]  i_new_minute,
    input  logic [5:0]  i_new_second,
    output t_time       o_next,
    output logic        o_rejected
);

    logic set_ok;

    assign set_ok = (i_new_year >= YEAR_FIRST) && (i_new_year <= YEAR_LAST)
                 && (i_new_month >= 4'd1) && (i_new_month <= MONTH_MAX)
                 && (i_new_day >= 5'd1)
                 && (i_new_day <= month_length(i_new_month, i_new_year))
                 && (i_new_hour <= HOUR_MAX) && (i_new_minute <= MIN_MAX)
                 && (i_new_second <= SEC_MAX);

    always_comb begin
        o_next     = i_cur;
        o_rejected = 1'b0;
        if (i_mode) begin
            if (set_ok) begin
                o_next.year   = i_new_year;
                o_next.month  = i_new_month;
                o_next.day    = i_new_day;
                o_next.hour   = i_new_hour;
                o_next.minute = i_new_minute;
                o_next.second = i_new_second;
            end else begin
                o_rejected = 1'b1;
            end
        end else if (i_cur.second < SEC_MAX) begin
            o_next.second = i_cur.second + 6'd1;
        end else begin
            o_next.second = 6'd0;
            if (i_cur.minute < MIN_MAX) begin
                o_next.minute = i_cur.minute + 6'd1;
            end else begin
                o_next.minute = 6'd0;
                if (i_cur.hour < HOUR_MAX) begin
                    o_next.hour = i_cur.hour + 5'd1;
                end else begin
                    o_next.hour = 5'd0;
                    if (i_cur.day < month_length(i_cur.month, i_cur.year)) begin
                        o_next.day = i_cur.day + 5'd1;
                    end else begin
                        o_next.day = 5'd1;
                        if (i_cur.month < MONTH_MAX) begin
                            o_next.month = i_cur.month + 4'd1;
                        end else begin
                            o_next.month = 4'd1;
                            o_next.year  = (i_cur.year >= YEAR_LAST) ? YEAR_FIRST
                                                                     : i_cur.year + 12'd1;
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== hw/rtl/calendar_clock_with_weekday.sv =====
`timescale 1ns / 1ps
// Channel  Handshake                  Payload
// input    i_in_valid / o_in_stall    i_mode, i_new_year .. i_new_second
// output   o_out_valid / i_out_stall  o_cur_year .. o_cur_second, o_weekday, o_set_rejected
//
// One item per cycle while the output is not stalled; a result passes through the
// stage-1 registers into the output registers before it can transfer out.
// The time registers update at the input transfer; the weekday is worked out
// in the output stage from them.
// Synchronous active-low reset sets 2000-01-01 00:00:00 and empties both stages.
// Input stalls only while both stages are full and the output is stalled.

module calendar_clock_with_weekday
    import ccw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [11:0] i_new_year,
    input  logic [3:0]  i_new_month,
    input  logic [4:0]  i_new_day,
    input  logic [4:0]  i_new_hour,
    input  logic [5:0]  i_new_minute,
    input  logic [5:0]  i_new_second,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_cur_year,
    output logic [3:0]  o_cur_month,
    output logic [4:0]  o_cur_day,
    output logic [4:0]  o_cur_hour,
    output logic [5:0]  o_cur_minute,
    output logic [5:0]  o_cur_second,
    output logic [2:0]  o_weekday,
    output logic        o_set_rejected
);

    t_time      r_time;
    t_time      n_time;
    logic       n_rej;
    logic       r_s1_valid;
    logic       r_s1_rej;
    logic       r_out_valid;
    t_time      r_out_time;
    logic [2:0] r_out_wday;
    logic       r_out_rej;
    logic       out_adv;
    logic       s1_adv;
    logic       in_xfer;

    ccw_next u_next (
        .i_cur        (r_time),
        .i_mode       (i_mode),
        .i_new_year   (i_new_year),
        .i_new_month  (i_new_month),
        .i_new_day    (i_new_day),
        .i_new_hour   (i_new_hour),
        .i_new_minute (i_new_minute),
        .i_new_second (i_new_second),
        .o_next       (n_time),
        .o_rejected   (n_rej)
    );

    assign out_adv    = !r_out_valid || !i_out_stall;
    assign s1_adv     = !r_s1_valid || out_adv;
    assign o_in_stall = !s1_adv;
    assign in_xfer    = i_in_valid && s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= TIME_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_time <= n_time;
            end
            if (s1_adv) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_rej <= n_rej;
        end
        if (out_adv && r_s1_valid) begin
            r_out_time <= r_time;
            r_out_wday <= weekday_of(r_time);
            r_out_rej  <= r_s1_rej;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cur_year     = r_out_time.year;
    assign o_cur_month    = r_out_time.month;
    assign o_cur_day      = r_out_time.day;
    assign o_cur_hour     = r_out_time.hour;
    assign o_cur_minute   = r_out_time.minute;
    assign o_cur_second   = r_out_time.second;
    assign o_weekday      = r_out_wday;
    assign o_set_rejected = r_out_rej;

endmodule

// ===== tb/calendar_clock_with_weekday_tb.sv =====
`timescale 1ns / 1ps

module calendar_clock_with_weekday_tb;
    import ccw_pkg::*;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SET  = 1'b1
    } clock_op_t;

    typedef struct packed {
        clock_op_t   op;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } clock_cmd_t;

    typedef struct packed {
        t_time      tm;
        logic [2:0] weekday;
        logic       rejected;
    } clock_reading_t;

    localparam int MONTH_CODES [12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
    localparam int ITEM_TARGET      = 1250;
    localparam int DRAIN_CYCLES     = 8;

    class calendar_scoreboard;
        t_time          now;
        clock_reading_t pending_readings[$];
        int             errors;
        int             checked;
        int             ticks;
        int             sets;
        int             refused;
        int             wraps;

        function new();
            now     = TIME_RESET;
            errors  = 0;
            checked = 0;
            ticks   = 0;
            sets    = 0;
            refused = 0;
            wraps   = 0;
        endfunction

        function bit is_leap(int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int month_days(int m, int y);
            case (m)
                2:                     return is_leap(y) ? 29 : 28;
                4, 6, 9, 11:           return 30;
                1, 3, 5, 7, 8, 10, 12: return 31;
                default:               return 0;
            endcase
        endfunction

        function logic [2:0] weekday_for(t_time t);
            int yc;
            int w;
            yc = int'(t.year) % 100;
            w  = (yc + yc / 4) % 7 + MONTH_CODES[int'(t.month) - 1]
               + ((t.year > CENTURY_SPLIT) ? int'(CCODE_LATE) : int'(CCODE_EARLY))
               + int'(t.day) + 7
               - ((is_leap(int'(t.year)) && t.month <= 4'd2) ? 1 : 0);
            w  = w % 7;
            return (w == 0) ? 3'd6 : 3'(w - 1);
        endfunction

        function void note_transfer(clock_cmd_t c);
            clock_reading_t r;
            r.rejected = 1'b0;
            if (c.op == CMD_SET) begin
                if (c.year >= YEAR_FIRST && c.year <= YEAR_LAST
                        && c.month >= 4'd1 && c.month <= MONTH_MAX
                        && c.day >= 5'd1 && c.day <= month_days(c.month, c.year)
                        && c.hour <= HOUR_MAX && c.minute <= MIN_MAX
                        && c.second <= SEC_MAX) begin
                    now.year   = c.year;
                    now.month  = c.month;
                    now.day    = c.day;
                    now.hour   = c.hour;
                    now.minute = c.minute;
                    now.second = c.second;
                    sets++;
                end else begin
                    r.rejected = 1'b1;
                    refused++;
                end
            end else begin
                ticks++;
                now.second = now.second + 6'd1;
                if (now.second > SEC_MAX) begin
                    now.second = 6'd0;
                    now.minute = now.minute + 6'd1;
                    if (now.minute > MIN_MAX) begin
                        now.minute = 6'd0;
                        now.hour   = now.hour + 5'd1;
                        if (now.hour > HOUR_MAX) begin
                            now.hour = 5'd0;
                            if (int'(now.day) >= month_days(now.month, now.year)) begin
                                now.day   = 5'd1;
                                now.month = now.month + 4'd1;
                                if (now.month > MONTH_MAX) begin
                                    now.month = 4'd1;
                                    now.year  = now.year + 12'd1;
                                    if (now.year > YEAR_LAST) begin
                                        now.year = YEAR_FIRST;
                                        wraps++;
                                    end
                                end
                            end else begin
                                now.day = now.day + 5'd1;
                            end
                        end
                    end
                end
            end
            r.tm      = now;
            r.weekday = weekday_for(now);
            pending_readings.push_back(r);
        endfunction

        function int pending_count();
            return pending_readings.size();
        endfunction

        function void check_field(string name, logic [11:0] want, logic [11:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(clock_reading_t got);
            clock_reading_t want;
            if (pending_readings.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                         $time, got.tm.year, got.tm.month, got.tm.day,
                         got.tm.hour, got.tm.minute, got.tm.second);
                return;
            end
            want = pending_readings.pop_front();
            checked++;
            check_field("year", want.tm.year, got.tm.year);
            check_field("month", 12'(want.tm.month), 12'(got.tm.month));
            check_field("day", 12'(want.tm.day), 12'(got.tm.day));
            check_field("hour", 12'(want.tm.hour), 12'(got.tm.hour));
            check_field("minute", 12'(want.tm.minute), 12'(got.tm.minute));
            check_field("second", 12'(want.tm.second), 12'(got.tm.second));
            check_field("weekday", 12'(want.weekday), 12'(got.weekday));
            check_field("set_rejected", 12'(want.rejected), 12'(got.rejected));
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic        i_mode         = 1'b0;
    logic [11:0] i_new_year     = '0;
    logic [3:0]  i_new_month    = '0;
    logic [4:0]  i_new_day      = '0;
    logic [4:0]  i_new_hour     = '0;
    logic [5:0]  i_new_minute   = '0;
    logic [5:0]  i_new_second   = '0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [11:0] o_cur_year;
    logic [3:0]  o_cur_month;
    logic [4:0]  o_cur_day;
    logic [4:0]  o_cur_hour;
    logic [5:0]  o_cur_minute;
    logic [5:0]  o_cur_second;
    logic [2:0]  o_weekday;
    logic        o_set_rejected;

    calendar_scoreboard sb;
    int burst_left  = 0;
    int issued      = 0;
    int stall_style = 0;
    int stall_left  = 0;
    int stall_phase = 0;

    calendar_clock_with_weekday u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_new_year     (i_new_year),
        .i_new_month    (i_new_month),
        .i_new_day      (i_new_day),
        .i_new_hour     (i_new_hour),
        .i_new_minute   (i_new_minute),
        .i_new_second   (i_new_second),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cur_year     (o_cur_year),
        .o_cur_month    (o_cur_month),
        .o_cur_day      (o_cur_day),
        .o_cur_hour     (o_cur_hour),
        .o_cur_minute   (o_cur_minute),
        .o_cur_second   (o_cur_second),
        .o_weekday      (o_weekday),
        .o_set_rejected (o_set_rejected)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(20, 200);
        end
        stall_left--;
        stall_phase++;
        case (stall_style)
            0:       i_out_stall = 1'b0;
            1:       i_out_stall = ($urandom_range(0, 3) == 0);
            2:       i_out_stall = ($urandom_range(0, 3) != 0);
            default: i_out_stall = stall_phase[2];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_transfer(clock_cmd_t'{op: clock_op_t'(i_mode), year: i_new_year,
                    month: i_new_month, day: i_new_day, hour: i_new_hour,
                    minute: i_new_minute, second: i_new_second});
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(clock_reading_t'{
                    tm: t_time'{year: o_cur_year, month: o_cur_month, day: o_cur_day,
                        hour: o_cur_hour, minute: o_cur_minute, second: o_cur_second},
                    weekday: o_weekday, rejected: o_set_rejected});
            end
        end
    end

    function automatic clock_cmd_t make_set(int y, int mo, int d, int h, int mi, int s);
        clock_cmd_t c;
        c.op     = CMD_SET;
        c.year   = 12'(y);
        c.month  = 4'(mo);
        c.day    = 5'(d);
        c.hour   = 5'(h);
        c.minute = 6'(mi);
        c.second = 6'(s);
        return c;
    endfunction

    function automatic clock_cmd_t make_tick();
        clock_cmd_t c;
        c    = make_set($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31),
                        $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
        c.op = CMD_TICK;
        return c;
    endfunction

    task automatic push_cmd(input clock_cmd_t c);
        int  gap;
        bit  accepted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid   = 1'b1;
        i_mode       = c.op;
        i_new_year   = c.year;
        i_new_month  = c.month;
        i_new_day    = c.day;
        i_new_hour   = c.hour;
        i_new_minute = c.minute;
        i_new_second = c.second;
        accepted = 1'b0;
        while (!accepted) begin
            @(posedge i_clk);
            accepted = !o_in_stall;
        end
        @(negedge i_clk);
        issued++;
    endtask

    initial begin
        #400_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int y;
        int mo;
        int d;
        int h;
        int mi;
        int s;
        int n;
        int kind;
        clock_cmd_t c;

        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        push_cmd(make_tick());
        push_cmd(make_set(2199, 12, 31, 23, 59, 59));
        push_cmd(make_tick());
        push_cmd(make_set(2099, 12, 31, 23, 59, 59));
        push_cmd(make_tick());
        push_cmd(make_set(2100, 2, 28, 23, 59, 59));
        push_cmd(make_tick());
        push_cmd(make_set(2100, 2, 29, 12, 0, 0));
        push_cmd(make_set(2000, 2, 29, 23, 59, 59));
        push_cmd(make_tick());
        push_cmd(make_set(2096, 2, 28, 23, 59, 59));
        push_cmd(make_tick());
        push_cmd(make_set(1999, 6, 15, 10, 20, 30));
        push_cmd(make_set(2200, 6, 15, 10, 20, 30));
        push_cmd(make_set(4095, 15, 31, 31, 63, 63));
        push_cmd(make_set(0, 0, 0, 0, 0, 0));
        push_cmd(make_set(2050, 0, 10, 1, 2, 3));
        push_cmd(make_set(2050, 13, 10, 1, 2, 3));
        push_cmd(make_set(2050, 7, 0, 1, 2, 3));
        push_cmd(make_set(2023, 4, 31, 1, 2, 3));
        push_cmd(make_set(2050, 7, 10, 24, 2, 3));
        push_cmd(make_set(2050, 7, 10, 1, 60, 3));
        push_cmd(make_set(2050, 7, 10, 1, 2, 60));
        push_cmd(make_set(2000, 1, 1, 0, 0, 0));
        c = make_set(4095, 15, 31, 31, 63, 63);
        c.op = CMD_TICK;
        push_cmd(c);

        while (issued < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            case ($urandom_range(0, 7))
                0:       y = 2099;
                1:       y = 2199;
                2:       y = 2100;
                3:       y = 4 * $urandom_range(500, 549);
                default: y = $urandom_range(2000, 2199);
            endcase
            mo = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
            d  = $urandom_range(1, sb.month_days(mo, y));
            h  = $urandom_range(0, 23);
            mi = $urandom_range(0, 59);
            s  = $urandom_range(0, 59);
            n  = $urandom_range(1, 4);
            if (kind <= 5) begin
                if ($urandom_range(0, 1)) d = sb.month_days(mo, y);
                if ($urandom_range(0, 1)) h = 23;
                if ($urandom_range(0, 1)) mi = 59;
                s = $urandom_range(40, 59);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
            end else if (kind == 8) begin
                y  = $urandom_range(0, 4095);
                mo = $urandom_range(0, 15);
                d  = $urandom_range(0, 31);
                h  = $urandom_range(0, 31);
                mi = $urandom_range(0, 63);
                s  = $urandom_range(0, 63);
                n  = $urandom_range(0, 2);
            end else if (kind == 9) begin
                case ($urandom_range(0, 5))
                    0: y = $urandom_range(0, 1) ? $urandom_range(0, 1999)
                                                : $urandom_range(2200, 4095);
                    1: mo = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
                    2: d = (sb.month_days(mo, y) == 31 || $urandom_range(0, 1)) ? 0
                         : $urandom_range(sb.month_days(mo, y) + 1, 31);
                    3: h = $urandom_range(24, 31);
                    4: mi = $urandom_range(60, 63);
                    default: s = $urandom_range(60, 63);
                endcase
            end
            push_cmd(make_set(y, mo, d, h, mi, s));
            repeat (n) push_cmd(make_tick());
        end

        i_in_valid = 1'b0;
        while (sb.pending_count() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d ticks, %0d accepted sets, %0d refused sets, %0d year wraps",
                 sb.ticks, sb.sets, sb.refused, sb.wraps);
        $display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
